/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the integer power block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FIP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FIP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fip_pkg.sv */
// Types, constants and helper functions of the integer power block.
`timescale 1ns / 1ps
`default_nettype none
package fip_pkg;

  localparam logic [31:0] SIGN_MASK   = 32'h8000_0000;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_base;
    logic acc_we;
    logic shift;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic msb;
    logic mul_done;
  } sts_t;

  // Leading zeros of a 24-bit word, 24 when the word is zero.
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/fip_fmul.sv */
// Five-stage binary32 multiplier, round to nearest even, subnormals kept.
`timescale 1ns / 1ps
`default_nettype none
module fip_fmul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      result
);

  // stage valids
  logic [3:0]  v_r;
  logic        done_r;

  // stage 0: unpack and special operands
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic        sp_nxt;
  logic [31:0] spv_nxt;
  logic        sp0_r, sgn0_r;
  logic [31:0] spv0_r;
  logic [7:0]  ea0_r, eb0_r;
  logic [23:0] ma0_r, mb0_r;

  always_comb begin
    sgn    = a[31] ^ b[31];
    a_zero = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
    b_zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    sp_nxt  = 1'b1;
    spv_nxt = {sgn, 31'd0};
    if (a_nan)       spv_nxt = a | fip_pkg::QUIET_BIT;
    else if (b_nan)  spv_nxt = b | fip_pkg::QUIET_BIT;
    else if (a_inf)  spv_nxt = b_zero ? fip_pkg::DEFAULT_NAN : ({sgn, 31'd0} | fip_pkg::INF_BITS);
    else if (b_inf)  spv_nxt = a_zero ? fip_pkg::DEFAULT_NAN : ({sgn, 31'd0} | fip_pkg::INF_BITS);
    else if (a_zero || b_zero) spv_nxt = {sgn, 31'd0};
    else sp_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    sp0_r  <= sp_nxt;
    spv0_r <= spv_nxt;
    sgn0_r <= sgn;
    ea0_r  <= (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb0_r  <= (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma0_r  <= {(a[30:23] != 8'd0), a[22:0]};
    mb0_r  <= {(b[30:23] != 8'd0), b[22:0]};
  end

  // stage 1: significand product
  logic        sp1_r, sgn1_r;
  logic [31:0] spv1_r;
  logic [8:0]  es1_r;
  logic [47:0] p1_r;

  always_ff @(posedge clk) begin
    sp1_r  <= sp0_r;
    spv1_r <= spv0_r;
    sgn1_r <= sgn0_r;
    es1_r  <= {1'b0, ea0_r} + {1'b0, eb0_r};
    p1_r   <= {24'd0, ma0_r} * {24'd0, mb0_r};
  end

  // stage 2: leading zeros of each half
  logic        sp2_r, sgn2_r;
  logic [31:0] spv2_r;
  logic [8:0]  es2_r;
  logic [47:0] p2_r;
  logic [4:0]  lzh2_r, lzl2_r;

  always_ff @(posedge clk) begin
    sp2_r  <= sp1_r;
    spv2_r <= spv1_r;
    sgn2_r <= sgn1_r;
    es2_r  <= es1_r;
    p2_r   <= p1_r;
    lzh2_r <= fip_pkg::lzc24(p1_r[47:24]);
    lzl2_r <= fip_pkg::lzc24(p1_r[23:0]);
  end

  // stage 3: normalize so the product sits in [2^47, 2^48)
  logic [5:0]  lz;
  logic        sp3_r, sgn3_r;
  logic [31:0] spv3_r;
  logic signed [10:0] e3_r;
  logic [47:0] p3_r;

  assign lz = (lzh2_r == 5'd24) ? (6'd24 + {1'b0, lzl2_r}) : {1'b0, lzh2_r};

  always_ff @(posedge clk) begin
    sp3_r  <= sp2_r;
    spv3_r <= spv2_r;
    sgn3_r <= sgn2_r;
    p3_r   <= p2_r << lz;
    e3_r   <= $signed({2'b00, es2_r}) - 11'sd126 - $signed({5'd0, lz});
  end

  // stage 4: round and pack
  logic signed [10:0] shr_w;
  logic [5:0]  shr;
  logic [47:0] qf, hf, mask;
  logic        half, sticky, rup;
  logic [24:0] qr;
  logic [31:0] r, res_nxt;
  logic [31:0] res_r;

  always_comb begin
    shr_w  = (e3_r < 11'sd1) ? (11'sd25 - e3_r) : 11'sd24;
    shr    = shr_w[5:0];
    qf     = p3_r >> shr;
    hf     = p3_r >> (shr - 6'd1);
    mask   = (48'd1 << (shr - 6'd1)) - 48'd1;
    half   = hf[0];
    sticky = |(p3_r & mask);
    rup    = half && (sticky || qf[0]);
    qr     = {1'b0, qf[23:0]} + {24'd0, rup};
    r      = {1'b0, e3_r[7:0] - 8'd1, 23'd0} + {7'd0, qr};
    if (sp3_r)                    res_nxt = spv3_r;
    else if (e3_r >= 11'sd255)    res_nxt = {sgn3_r, 31'd0} | fip_pkg::INF_BITS;
    else if (shr_w > 11'sd49)     res_nxt = {sgn3_r, 31'd0};
    else if (e3_r < 11'sd1)       res_nxt = {sgn3_r, 7'd0, qr[23:0]};
    else if (r >= fip_pkg::INF_BITS) res_nxt = {sgn3_r, 31'd0} | fip_pkg::INF_BITS;
    else                          res_nxt = {sgn3_r, 31'd0} | r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      done_r <= 1'b0;
    end else begin
      v_r    <= {v_r[2:0], start};
      done_r <= v_r[3];
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

/* rtl/fip_datapath.sv */
// Datapath: accumulator, base, exponent shifter, result register and multiplier.
`timescale 1ns / 1ps
`default_nettype none
module fip_datapath #(
  parameter int EXP_WIDTH = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fip_pkg::cmd_t        cmd,
  output fip_pkg::sts_t             sts,
  input  wire logic [31:0]          in_base_bits,
  input  wire logic [EXP_WIDTH-1:0] in_exponent,
  output logic [31:0]               res_bits
);

  logic [31:0]          acc_r, base_r, res_r, mul_b, mul_res;
  logic [EXP_WIDTH-1:0] exp_r;
  logic                 mul_done;

  // shared multiplier: square or times base
  assign mul_b = cmd.mul_base ? base_r : acc_r;

  fip_fmul u_fmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .a      (acc_r),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // operand, accumulator and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r  <= fip_pkg::ONE_BITS;
      base_r <= in_base_bits;
      exp_r  <= in_exponent;
    end else begin
      if (cmd.acc_we) acc_r <= mul_res;
      if (cmd.shift)  exp_r <= exp_r << 1;
    end
    if (cmd.res_load) res_r <= acc_r;
  end

  assign sts.msb      = exp_r[EXP_WIDTH-1];
  assign sts.mul_done = mul_done;
  assign res_bits     = res_r;

endmodule
`default_nettype wire

/* rtl/fip_ctrl.sv */
// Controller: sequences square-and-multiply over the exponent bits.
`timescale 1ns / 1ps
`default_nettype none
module fip_ctrl #(
  parameter int EXP_WIDTH = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire fip_pkg::sts_t sts,
  output fip_pkg::cmd_t      cmd
);

  localparam int CW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  fip_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ov_r, ov_nxt;
  logic            out_free;

  assign out_free = !ov_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fip_pkg::ST_IDLE:     if (in_valid) state_nxt = fip_pkg::ST_SQ;
      fip_pkg::ST_SQ:       state_nxt = fip_pkg::ST_SQ_WAIT;
      fip_pkg::ST_SQ_WAIT:
        if (sts.mul_done) state_nxt = sts.msb ? fip_pkg::ST_MUL : fip_pkg::ST_NEXT;
      fip_pkg::ST_MUL:      state_nxt = fip_pkg::ST_MUL_WAIT;
      fip_pkg::ST_MUL_WAIT: if (sts.mul_done) state_nxt = fip_pkg::ST_NEXT;
      fip_pkg::ST_NEXT:
        state_nxt = (cnt_r == '0) ? fip_pkg::ST_FINISH : fip_pkg::ST_SQ;
      fip_pkg::ST_FINISH:   if (out_free) state_nxt = fip_pkg::ST_IDLE;
      default:              state_nxt = fip_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      fip_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fip_pkg::ST_SQ:       cmd.mul_start = 1'b1;
      fip_pkg::ST_SQ_WAIT:  cmd.acc_we = sts.mul_done;
      fip_pkg::ST_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_base  = 1'b1;
      end
      fip_pkg::ST_MUL_WAIT: begin
        cmd.mul_base = 1'b1;
        cmd.acc_we   = sts.mul_done;
      end
      fip_pkg::ST_NEXT:     cmd.shift = 1'b1;
      fip_pkg::ST_FINISH:   cmd.res_load = out_free;
      default:              cmd = '0;
    endcase
  end

  // bit counter and output valid
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) cnt_nxt = CW'(EXP_WIDTH - 1);
    else if (cmd.shift && (cnt_r != '0)) cnt_nxt = cnt_r - CW'(1);
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (cmd.res_load)      ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fip_pkg::ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

/* rtl/float_integer_power.sv */
// Raises a binary32 base to an unsigned integer power by square-and-multiply,
// scanning the exponent from its top bit down with one shared five-stage
// float multiplier (round to nearest even, subnormals kept, NaNs quieted).
// For each exponent bit the accumulator is squared and then, if the bit is
// one, multiplied by the base; each product waits for the one before it.
// A finished result sits in an output register, so a new transaction is
// taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module float_integer_power #(
  parameter int EXP_WIDTH = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_base_bits,
  input  wire logic [EXP_WIDTH-1:0] in_exponent,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_result_bits
);

  fip_pkg::cmd_t cmd;
  fip_pkg::sts_t sts;

  fip_ctrl #(.EXP_WIDTH(EXP_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fip_datapath #(.EXP_WIDTH(EXP_WIDTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_base_bits (in_base_bits),
    .in_exponent  (in_exponent),
    .res_bits     (out_result_bits)
  );

  // checks on controller and datapath interplay
  `FIP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `FIP_ASSERT_NXT(a_result_shown, cmd.res_load, out_valid, "result load without valid")
  `FIP_ASSERT_NXT(a_one_mul_in_flight, cmd.mul_start, !sts.mul_done, "overlapping multiplies")

endmodule
`default_nettype wire
